// ===== rtl/ccf_pkg.sv =====
// Shared constants, command codes and the result record of the call control unit.
`default_nettype none

package ccf_pkg;

  // Width of the peer id ports; the stored peer may be narrower.
  localparam int unsigned PEER_PORT_BITS = 64;
  localparam int unsigned PEER_ID_BITS_DEFAULT = 64;

  // Time-in-phase counter and timeout registers.
  localparam int unsigned CNT_BITS = 20;
  localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};
  localparam logic [CNT_BITS-1:0] CALLING_TIMEOUT_RST = 20'd30000;
  localparam logic [CNT_BITS-1:0] RINGING_TIMEOUT_RST = 20'd15000;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_BITS = 4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CALLING_TIMEOUT = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RINGING_TIMEOUT = 4'd1;

  // Command codes.
  localparam int unsigned CMD_BITS = 4;
  localparam logic [CMD_BITS-1:0] CMD_OFFER        = 4'd0;
  localparam logic [CMD_BITS-1:0] CMD_RECV_OFFER   = 4'd1;
  localparam logic [CMD_BITS-1:0] CMD_RECV_ANSWER  = 4'd2;
  localparam logic [CMD_BITS-1:0] CMD_RECV_REJECT  = 4'd3;
  localparam logic [CMD_BITS-1:0] CMD_RECV_TIMEOUT = 4'd4;
  localparam logic [CMD_BITS-1:0] CMD_TIMEOUT      = 4'd5;
  localparam logic [CMD_BITS-1:0] CMD_CLOSE        = 4'd6;
  localparam logic [CMD_BITS-1:0] CMD_ANSWER       = 4'd7;
  localparam logic [CMD_BITS-1:0] CMD_REJECT       = 4'd8;
  localparam logic [CMD_BITS-1:0] CMD_RECV_BYE     = 4'd9;

  // Action codes.
  localparam logic ACT_COMMAND = 1'b0;
  localparam logic ACT_TICK    = 1'b1;

  // Result fields other than the peer id.
  typedef struct packed {
    logic       status;
    logic [1:0] call_state;
    logic [1:0] prior_state;
    logic       state_changed;
    logic       timed_out;
    logic       initiator;
  } ccf_result_t;

endpackage

`default_nettype wire

// ===== rtl/ccf_cfg_regs.sv =====
// Timeout configuration registers of the call control unit.
`default_nettype none

module ccf_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               wr_en,
  input  wire logic [ccf_pkg::CFG_INDEX_BITS-1:0] wr_index,
  input  wire logic [ccf_pkg::CNT_BITS-1:0]       wr_data,
  output logic      [ccf_pkg::CNT_BITS-1:0]       calling_timeout,
  output logic      [ccf_pkg::CNT_BITS-1:0]       ringing_timeout
);
  import ccf_pkg::*;

  // Writes to an index beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      calling_timeout <= CALLING_TIMEOUT_RST;
      ringing_timeout <= RINGING_TIMEOUT_RST;
    end else if (wr_en) begin
      if (wr_index == CFG_CALLING_TIMEOUT) begin
        calling_timeout <= wr_data;
      end
      if (wr_index == CFG_RINGING_TIMEOUT) begin
        ringing_timeout <= wr_data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ccf_step.sv =====
// Call phase state, peer store and time-in-phase counter with their update logic.
`default_nettype none

module ccf_step #(
  parameter int unsigned PEER_ID_BITS = ccf_pkg::PEER_ID_BITS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         fire,
  input  wire logic                         action,
  input  wire logic [ccf_pkg::CMD_BITS-1:0] command,
  input  wire logic                         has_peer,
  input  wire logic [PEER_ID_BITS-1:0]      peer_id,
  input  wire logic [ccf_pkg::CNT_BITS-1:0] calling_timeout,
  input  wire logic [ccf_pkg::CNT_BITS-1:0] ringing_timeout,
  output ccf_pkg::ccf_result_t              res,
  output logic      [PEER_ID_BITS-1:0]      peer_out
);
  import ccf_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_CALLING  = 2'd1,
    PH_INCOMING = 2'd2,
    PH_INCALL   = 2'd3
  } phase_t;

  phase_t                  phase;
  phase_t                  phase_next;
  logic [CNT_BITS-1:0]     time_in_phase;
  logic [CNT_BITS-1:0]     time_in_phase_next;
  logic [CNT_BITS-1:0]     cnt_inc;
  logic [PEER_ID_BITS-1:0] peer;
  logic [PEER_ID_BITS-1:0] peer_next;
  logic                    we_initiated;
  logic                    we_initiated_next;
  logic                    status;
  logic                    expired;

  assign cnt_inc = (time_in_phase == CNT_MAX) ? time_in_phase
                                              : time_in_phase + CNT_BITS'(1);

  // The timeout is compared with the count after the increment.
  assign expired = ((phase == PH_CALLING) && (cnt_inc >= calling_timeout)) ||
                   ((phase == PH_INCOMING) && (cnt_inc >= ringing_timeout));

  always_comb begin
    phase_next         = phase;
    time_in_phase_next = time_in_phase;
    peer_next          = peer;
    we_initiated_next  = we_initiated;
    status             = 1'b0;

    if (action == ACT_TICK) begin
      time_in_phase_next = cnt_inc;
      if (expired) begin
        phase_next = PH_IDLE;
      end
    end else begin
      case (phase)
        PH_IDLE: begin
          if (has_peer && (command == CMD_OFFER)) begin
            phase_next        = PH_CALLING;
            peer_next         = peer_id;
            we_initiated_next = 1'b1;
          end else if (has_peer && (command == CMD_RECV_OFFER)) begin
            phase_next        = PH_INCOMING;
            peer_next         = peer_id;
            we_initiated_next = 1'b0;
          end else begin
            status = 1'b1;
          end
        end
        PH_CALLING: begin
          if (command == CMD_RECV_ANSWER) begin
            phase_next = PH_INCALL;
          end else if (command inside {CMD_RECV_REJECT, CMD_RECV_TIMEOUT,
                                       CMD_TIMEOUT, CMD_CLOSE}) begin
            phase_next = PH_IDLE;
          end else begin
            status = 1'b1;
          end
        end
        PH_INCOMING: begin
          if (command == CMD_ANSWER) begin
            phase_next = PH_INCALL;
          end else if (command inside {CMD_REJECT, CMD_TIMEOUT, CMD_CLOSE}) begin
            phase_next = PH_IDLE;
          end else begin
            status = 1'b1;
          end
        end
        PH_INCALL: begin
          if (command inside {CMD_CLOSE, CMD_RECV_BYE, CMD_RECV_REJECT}) begin
            phase_next = PH_IDLE;
          end else begin
            status = 1'b1;
          end
        end
        default: begin
          status = 1'b1;
        end
      endcase
    end

    // Every phase change restarts the counter, and a return to idle drops the peer.
    if (phase_next != phase) begin
      time_in_phase_next = '0;
      if (phase_next == PH_IDLE) begin
        peer_next         = '0;
        we_initiated_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      time_in_phase <= '0;
      peer          <= '0;
      we_initiated  <= 1'b0;
    end else if (fire) begin
      phase         <= phase_next;
      time_in_phase <= time_in_phase_next;
      peer          <= peer_next;
      we_initiated  <= we_initiated_next;
    end
  end

  always_comb begin
    res.status        = status;
    res.call_state    = phase_next;
    res.prior_state   = phase;
    res.state_changed = (phase_next != phase);
    res.timed_out     = (action == ACT_TICK) && expired;
    res.initiator     = we_initiated_next;
  end

  assign peer_out = peer_next;

endmodule

`default_nettype wire

// ===== rtl/call_control_fsm_unit.sv =====
// Top level of the call control unit: input register, phase update and result register.
`default_nettype none

// Channel   Handshake               Contents
// item      item_valid/item_stall   action, command, has_peer, peer_id
// result    result_valid/result_stall  status, call_state, prior_state,
//                                   state_changed, timed_out, current_peer, initiator
// config    cfg_valid/cfg_ready     cfg_index, cfg_data (20-bit timeout values)
//
// One word is taken every cycle while the item side is not stalled. A word is held in the
// input register, and its result is then registered in the result register, where it
// waits until it is accepted.
// The phase update between the two registers is a single pass per word.
// Reset is synchronous on rst and returns the unit to idle with no peer and the
// default timeouts. A stall on the result side holds the result register, and the
// input register still takes one further word before the item side is stalled.
// Configuration writes are always ready.

module call_control_fsm_unit #(
  parameter int unsigned PEER_ID_BITS = ccf_pkg::PEER_ID_BITS_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,

  input  wire logic                               item_valid,
  output logic                                    item_stall,
  input  wire logic                               action,
  input  wire logic [ccf_pkg::CMD_BITS-1:0]       command,
  input  wire logic                               has_peer,
  input  wire logic [ccf_pkg::PEER_PORT_BITS-1:0] peer_id,

  output logic                                    result_valid,
  input  wire logic                               result_stall,
  output logic                                    status,
  output logic      [1:0]                         call_state,
  output logic      [1:0]                         prior_state,
  output logic                                    state_changed,
  output logic                                    timed_out,
  output logic      [ccf_pkg::PEER_PORT_BITS-1:0] current_peer,
  output logic                                    initiator,

  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [ccf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [ccf_pkg::CNT_BITS-1:0]       cfg_data
);
  import ccf_pkg::*;

  // Input register.
  logic                    in_full;
  logic                    in_action;
  logic [CMD_BITS-1:0]     in_command;
  logic                    in_has_peer;
  logic [PEER_ID_BITS-1:0] in_peer;

  // Result register.
  ccf_result_t             out_res;
  logic [PEER_ID_BITS-1:0] out_peer;

  ccf_result_t             step_res;
  logic [PEER_ID_BITS-1:0] step_peer;
  logic [CNT_BITS-1:0]     calling_timeout;
  logic [CNT_BITS-1:0]     ringing_timeout;
  logic                    take;
  logic                    advance;

  assign cfg_ready = 1'b1;

  // A word moves on whenever the result register is empty or being emptied.
  assign advance    = in_full && !(result_valid && result_stall);
  assign item_stall = in_full && result_valid && result_stall;
  assign take       = item_valid && !item_stall;

  ccf_cfg_regs u_cfg (
    .clk             (clk),
    .rst             (rst),
    .wr_en           (cfg_valid && cfg_ready),
    .wr_index        (cfg_index),
    .wr_data         (cfg_data),
    .calling_timeout (calling_timeout),
    .ringing_timeout (ringing_timeout)
  );

  ccf_step #(
    .PEER_ID_BITS (PEER_ID_BITS)
  ) u_step (
    .clk             (clk),
    .rst             (rst),
    .fire            (advance),
    .action          (in_action),
    .command         (in_command),
    .has_peer        (in_has_peer),
    .peer_id         (in_peer),
    .calling_timeout (calling_timeout),
    .ringing_timeout (ringing_timeout),
    .res             (step_res),
    .peer_out        (step_peer)
  );

  // Only the low PEER_ID_BITS of the peer id are kept.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_action   <= action;
      in_command  <= command;
      in_has_peer <= has_peer;
      in_peer     <= peer_id[PEER_ID_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res  <= step_res;
      out_peer <= step_peer;
    end
  end

  assign status        = out_res.status;
  assign call_state    = out_res.call_state;
  assign prior_state   = out_res.prior_state;
  assign state_changed = out_res.state_changed;
  assign timed_out     = out_res.timed_out;
  assign initiator     = out_res.initiator;
  assign current_peer  = PEER_PORT_BITS'(out_peer);

endmodule

`default_nettype wire
